>>> design/tdpc_pkg.sv
`default_nettype none

package tdpc_pkg;

    // Field widths
    localparam int VALUE_WIDTH = 31;
    localparam int TALLY_WIDTH = 31;

    // Divisors never pass the square root of the largest value, plus one odd step
    localparam int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 2;
    // Square of the divisor, with headroom for the step past the root
    localparam int SQ_WIDTH    = VALUE_WIDTH + 2;
    localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);
    localparam logic [DIV_WIDTH-1:0]   FIRST_ODD_DIV  = DIV_WIDTH'(3);
    localparam logic [SQ_WIDTH-1:0]    FIRST_ODD_SQ   = SQ_WIDTH'(9);
    localparam logic [TALLY_WIDTH-1:0] TALLY_MAX      = {TALLY_WIDTH{1'b1}};

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   restart;
    } item_t;

    typedef struct packed {
        logic                   is_prime;
        logic [TALLY_WIDTH-1:0] primes_so_far;
    } result_t;

    // Outcome of the front-end screen
    typedef enum logic [1:0] {
        CLS_NOT_PRIME,
        CLS_PRIME,
        CLS_TRIAL
    } cls_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   restart;
        cls_t                   cls;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> design/trial_division_prime_counter_top.sv
`default_nettype none

// Trial-division prime counter. Each transaction on the item channel carries a
// 31-bit candidate and a restart flag; each transaction on the result channel
// returns whether that candidate is prime and the running prime count after it
// (cleared first when restart is set, saturating at 2^31-1). Results come back
// one per item, in order. A front end screens values below three and even
// values and queues up to two items, so new items are taken while the back end
// is busy or a result waits. Screened items skip trial division in the back end.
// An odd candidate n of three or more is divided by 3, 5, 7, ... while the
// divisor squared does not exceed n, stopping at the first zero remainder; every
// divisor is worked bit-serially in the single remainder unit, so a prime near
// 2^31 takes the longest, and the back end pops no new item until a result is
// registered.

module trial_division_prime_counter_top
    import tdpc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      pop_job;

    tdpc_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    tdpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    tdpc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .job          (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> design/tdpc_front.sv
`default_nettype none

module tdpc_front
    import tdpc_pkg::*;
(
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire item_t     item,
    input  wire q_status_t q_status,
    output logic           push,
    output job_t           job
);

    // Stall while the queue has no room
    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    // Screen out the values that need no trial division
    always_comb
    begin
        job.value   = item.value;
        job.restart = item.restart;
        if (item.value < SMALLEST_PRIME)
        begin
            job.cls = CLS_NOT_PRIME;
        end
        else if (item.value == SMALLEST_PRIME)
        begin
            job.cls = CLS_PRIME;
        end
        else if (!item.value[0])
        begin
            job.cls = CLS_NOT_PRIME;
        end
        else
        begin
            job.cls = CLS_TRIAL;
        end
    end

endmodule

`default_nettype wire

>>> design/tdpc_queue.sv
`default_nettype none

module tdpc_queue
    import tdpc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire job_t  push_job,
    input  wire logic  pop,
    output job_t       pop_job,
    output q_status_t  status
);

    job_t                  entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QCNT_WIDTH-1:0] count_reg;

    assign status.full  = (count_reg == QCNT_WIDTH'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold queued jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> design/tdpc_back.sv
`default_nettype none

module tdpc_back
    import tdpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_status,
    input  wire job_t      job,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output result_t        result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                 state_reg,     state_next;
    logic [VALUE_WIDTH-1:0] value_reg,     value_next;
    logic                   restart_reg,   restart_next;
    logic                   prime_reg,     prime_next;
    logic [DIV_WIDTH-1:0]   div_reg,       div_next;
    logic [SQ_WIDTH-1:0]    sq_reg,        sq_next;
    logic [DIV_WIDTH-1:0]   rem_reg,       rem_next;
    logic [BIT_WIDTH-1:0]   bit_reg,       bit_next;
    logic [TALLY_WIDTH-1:0] tally_reg,     tally_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg,       out_next;

    logic [DIV_WIDTH:0]     rem_shift;
    logic [DIV_WIDTH:0]     rem_sub;
    logic                   rem_ge;
    logic [DIV_WIDTH-1:0]   rem_step;
    logic                   past_root;
    logic [TALLY_WIDTH-1:0] tally_base;
    logic                   out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;
    assign pop          = (state_reg == ST_IDLE) && !q_status.empty;

    // One restoring step of value mod divisor, most significant bit first
    assign rem_shift = {rem_reg, value_reg[bit_reg]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_step  = rem_ge ? rem_sub[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];

    // Stop once the divisor squared passes the value
    assign past_root = (sq_reg > SQ_WIDTH'(value_reg));

    // Clear the tally first on restart, then count this item
    assign tally_base = restart_reg ? '0 : tally_reg;

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        restart_next   = restart_reg;
        prime_next     = prime_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Drop the result once taken
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    value_next   = job.value;
                    restart_next = job.restart;
                    div_next     = FIRST_ODD_DIV;
                    sq_next      = FIRST_ODD_SQ;
                    prime_next   = (job.cls == CLS_PRIME);
                    if (job.cls == CLS_TRIAL)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_CHECK:
            begin
                if (past_root)
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    bit_next   = BIT_WIDTH'(VALUE_WIDTH - 1);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = rem_step;
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    if (rem_step == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        sq_next    = sq_reg + SQ_WIDTH'({div_reg, 2'b00})
                                   + SQ_WIDTH'(4);
                        div_next   = div_reg + DIV_WIDTH'(2);
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (prime_reg && (tally_base != TALLY_MAX))
                    begin
                        tally_next = tally_base + 1'b1;
                    end
                    else
                    begin
                        tally_next = tally_base;
                    end
                    out_next.is_prime      = prime_reg;
                    out_next.primes_so_far = tally_next;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        restart_reg <= restart_next;
        prime_reg   <= prime_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

>>> verif/tb_trial_division_prime_counter_top.sv
`timescale 1ns / 100ps

module tb_trial_division_prime_counter_top;
    import tdpc_pkg::*;

    // Tracks the running prime count and the results still owed by the block
    class tally_board;
        logic [TALLY_WIDTH-1:0] running_tally;
        result_t                owed_results[$];
        int                     errors;

        function new();
            running_tally = '0;
            errors        = 0;
        endfunction

        // Decide primality by odd trial divisors up to the square root
        function bit divides_to_prime(longint unsigned n);
            longint unsigned d;
            if (n < longint'(SMALLEST_PRIME))
                return 1'b0;
            if (n == longint'(SMALLEST_PRIME))
                return 1'b1;
            if ((n % longint'(SMALLEST_PRIME)) == 0)
                return 1'b0;
            for (d = 3; d <= n / d; d += 2)
            begin
                if ((n % d) == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Advance the count for an accepted transaction and queue its result
        function void note_item(item_t it);
            result_t exp_res;
            bit      prime;
            prime = divides_to_prime(longint'(it.value));
            if (it.restart)
                running_tally = '0;
            if (prime && running_tally != TALLY_MAX)
                running_tally = running_tally + 1'b1;
            exp_res.is_prime      = prime;
            exp_res.primes_so_far = running_tally;
            owed_results.push_back(exp_res);
        endfunction

        // Compare a returned transaction with the oldest owed result
        function void check_result(result_t got);
            result_t exp_res;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result is_prime=%0b primes_so_far=%0d",
                         $time, got.is_prime, got.primes_so_far);
                errors++;
                return;
            end
            exp_res = owed_results.pop_front();
            if (got.is_prime !== exp_res.is_prime)
            begin
                $display("%0t: is_prime mismatch: expected %0b, actual %0b",
                         $time, exp_res.is_prime, got.is_prime);
                errors++;
            end
            if (got.primes_so_far !== exp_res.primes_so_far)
            begin
                $display("%0t: primes_so_far mismatch: expected %0d, actual %0d",
                         $time, exp_res.primes_so_far, got.primes_so_far);
                errors++;
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int      stall_pct;
    tally_board board = new();

    trial_division_prime_counter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Check each result transaction as it is taken
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    // Offer one transaction, idling beforehand at the given rate; starts and ends at a falling edge
    task automatic send_item(input item_t it, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        board.note_item(it);
        @(negedge clk);
    endtask

    // Hold off the item channel until every owed result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (board.outstanding() != 0)
            @(negedge clk);
    endtask

    // Mostly small candidates; large ones are even or carry a small factor to stay quick
    function automatic item_t random_item();
        item_t                  it;
        int                     pick;
        int unsigned            factor;
        logic [VALUE_WIDTH-1:0] wide;
        pick = $urandom_range(0, 99);
        wide = VALUE_WIDTH'($urandom());
        if (pick < 50)
            it.value = VALUE_WIDTH'($urandom_range(0, 4095));
        else if (pick < 70)
            it.value = VALUE_WIDTH'($urandom_range(0, 65535));
        else if (pick < 80)
            it.value = VALUE_WIDTH'($urandom_range(0, 262143));
        else if (pick < 90)
            it.value = {wide[VALUE_WIDTH-1:1], 1'b0};
        else
        begin
            case ($urandom_range(0, 4))
                0:       factor = 3;
                1:       factor = 5;
                2:       factor = 7;
                3:       factor = 11;
                default: factor = 13;
            endcase
            it.value = VALUE_WIDTH'(factor * $urandom_range(1, 32'h7FFF_FFFF / factor));
        end
        it.restart = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    // Overall time limit
    initial
    begin
        #72_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        item_t directed[$];
        int    idle_rates[4];
        int    stall_rates[4];
        int    phase;
        int    n;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        stall_pct    = 0;
        idle_rates   = '{0, 46, 0, 31};
        stall_rates  = '{0, 0, 46, 31};

        // Small values, odd squares, restarts on prime and non-prime, field extremes
        directed = '{
            '{value: 31'd0,          restart: 1'b0},
            '{value: 31'd1,          restart: 1'b0},
            '{value: 31'd2,          restart: 1'b0},
            '{value: 31'd3,          restart: 1'b0},
            '{value: 31'd4,          restart: 1'b0},
            '{value: 31'd5,          restart: 1'b1},
            '{value: 31'd9,          restart: 1'b0},
            '{value: 31'd15,         restart: 1'b0},
            '{value: 31'd25,         restart: 1'b0},
            '{value: 31'd49,         restart: 1'b0},
            '{value: 31'd97,         restart: 1'b0},
            '{value: 31'd121,        restart: 1'b0},
            '{value: 31'd169,        restart: 1'b0},
            '{value: 31'd8,          restart: 1'b1},
            '{value: 31'd65537,      restart: 1'b0},
            '{value: 31'h7FFF_FFFF,  restart: 1'b0},
            '{value: 31'h7FFF_FFFE,  restart: 1'b0},
            '{value: 31'h4000_0000,  restart: 1'b0},
            '{value: 31'h4000_0001,  restart: 1'b0},
            '{value: 31'd0,          restart: 1'b1},
            '{value: 31'd1,          restart: 1'b1},
            '{value: 31'd3,          restart: 1'b1},
            '{value: 31'd7,          restart: 1'b0}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_item(directed[i], 0);
        drain_results();

        // Run the random traffic under each pattern of item idling and result stalls
        for (phase = 0; phase < 4; phase++)
        begin
            stall_pct = stall_rates[phase];
            for (n = 0; n < 145; n++)
                send_item(random_item(), idle_rates[phase]);
            drain_results();
        end

        stall_pct = 0;
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
